/* hdl/spgb_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, codes and helpers for the spatial grid broadphase block.
// Used by spgb_div and spatial_grid_broadphase_top.
package spgb_pkg;

	localparam int ID_W     = 6;
	localparam int POS_W    = 16;
	localparam int CELL_W   = 4;
	localparam int CFG_W    = 16;
	localparam int CELL_CAP = 4;
	localparam int CNT_W    = 3;
	localparam int SLOT_W   = 2;
	localparam int CIDX_W   = 2 * CELL_W;
	localparam int MIDX_W   = CIDX_W + SLOT_W;
	localparam int NUM_OBJ  = 64;
	localparam int NUM_CELL = 256;
	localparam int NUM_SLOT = NUM_CELL * CELL_CAP;
	localparam int DIV_W    = POS_W + 1;
	localparam int K_W      = 4;
	localparam int STAT_W   = 2;
	localparam int KIND_W   = 3;

	localparam logic [K_W-1:0] K_LAST = 4'd8;

	localparam logic [KIND_W-1:0] KIND_PLACE_POS  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PLACE_CELL = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MOVE       = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REMOVE     = 3'd3;
	localparam logic [KIND_W-1:0] KIND_QUERY      = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_OUTSIDE = 2'd2;
	localparam logic [STAT_W-1:0] ST_BAD     = 2'd3;

	localparam logic REG_CELL_WIDTH  = 1'b0;
	localparam logic REG_CELL_HEIGHT = 1'b1;

	// Row-major cell index: (y + 8) * 16 + (x + 8).
	function automatic logic [CIDX_W-1:0] cell_index(input logic [CELL_W-1:0] x,
		input logic [CELL_W-1:0] y);
		cell_index = {~y[CELL_W-1], y[CELL_W-2:0], ~x[CELL_W-1], x[CELL_W-2:0]};
	endfunction

	// Neighbour offsets in visit order, as 2-bit signed values.
	function automatic logic [1:0] q_dx(input logic [K_W-1:0] k);
		unique case (k)
			4'd0, 4'd3, 4'd6: q_dx = 2'b11;
			4'd1, 4'd4, 4'd7: q_dx = 2'b00;
			default:          q_dx = 2'b01;
		endcase
	endfunction

	function automatic logic [1:0] q_dy(input logic [K_W-1:0] k);
		unique case (k)
			4'd0, 4'd1, 4'd2: q_dy = 2'b01;
			4'd3, 4'd4, 4'd5: q_dy = 2'b00;
			default:          q_dy = 2'b11;
		endcase
	endfunction

endpackage

/* hdl/spgb_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Depends on spgb_pkg for the operand width.
module spgb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [spgb_pkg::DIV_W-1:0] num,
	input  logic [spgb_pkg::DIV_W-1:0] den,
	output logic                      done,
	output logic [spgb_pkg::DIV_W-1:0] quot
);

	logic [spgb_pkg::DIV_W-1:0] num_q, den_q, rem_q, quot_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q, done_q;
	logic [spgb_pkg::DIV_W:0]   sh;
	logic                       ge;

	assign sh = {rem_q, num_q[spgb_pkg::DIV_W-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'(spgb_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == 5'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= {num_q[spgb_pkg::DIV_W-2:0], 1'b0};
			rem_q  <= ge ? spgb_pkg::DIV_W'(sh - {1'b0, den_q}) : sh[spgb_pkg::DIV_W-1:0];
			quot_q <= {quot_q[spgb_pkg::DIV_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done_q) else $error("divider start not taken");
	a_count_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != 5'd0) else $error("divider count ran out while busy");

endmodule

/* hdl/spatial_grid_broadphase_top.sv */
`timescale 1ns / 1ps
// Uniform-grid object index with place, move, remove and 3x3 neighbourhood query.
// Depends on spgb_pkg and spgb_div.
//
// One item is worked at a time. Place by position and move first run the two 17-step
// restoring dividers that map the position to a cell; a move that changes cell then
// compacts the list of the old cell. Remove compacts the list of the object's cell.
// A query visits the neighbour cells in turn, skips those outside the window and
// reads each hit through the single read port of the member memory. A stalled result
// output holds the sequencer. No clearing pass follows reset: object entries and cell
// counts carry valid flops, member slots are read only below the count.
module spatial_grid_broadphase_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// object_id[5:0], position_x[21:6], position_y[37:22], cell_x[41:38], cell_y[45:42]
	input  logic [47:0] s_tdata,
	// kind[2:0]
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], found_id[7:2], result_cell_x[11:8], result_cell_y[15:12]
	output logic [15:0] m_tdata,
	// found[0]
	output logic        m_tuser,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [15:0] cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DIVS  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_CHK   = 4'd3;
	localparam logic [3:0] S_TCNT  = 4'd4;
	localparam logic [3:0] S_DRCNT = 4'd5;
	localparam logic [3:0] S_DRRD  = 4'd6;
	localparam logic [3:0] S_APP   = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;
	localparam logic [3:0] S_QCELL = 4'd9;
	localparam logic [3:0] S_QCNT  = 4'd10;
	localparam logic [3:0] S_QMEM  = 4'd11;
	localparam logic [3:0] S_QEND  = 4'd12;

	localparam int CW = spgb_pkg::CELL_W;
	localparam int IW = spgb_pkg::ID_W;
	localparam int NW = spgb_pkg::CNT_W;

	// ---------------- configuration ----------------
	logic [spgb_pkg::CFG_W-1:0] cw_q, ch_q, cfg_v;
	assign cfg_v = (cfg_data == '0) ? spgb_pkg::CFG_W'(1) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= spgb_pkg::CFG_W'(16);
			ch_q <= spgb_pkg::CFG_W'(16);
		end else if (cfg_we) begin
			if (cfg_idx == spgb_pkg::REG_CELL_WIDTH) cw_q <= cfg_v;
			if (cfg_idx == spgb_pkg::REG_CELL_HEIGHT) ch_q <= cfg_v;
		end
	end

	// ---------------- sequencer registers ----------------
	logic [3:0]                state_q, state_d;
	logic [2:0]                kind_q, kind_d;
	logic [IW-1:0]             id_q, id_d, hit_q, hit_d;
	logic [15:0]               px_q, px_d, py_q, py_d;
	logic [CW-1:0]             qx_q, qx_d, qy_q, qy_d, tx_q, tx_d, ty_q, ty_d;
	logic [CW-1:0]             ocx_q, ocx_d, ocy_q, ocy_d, rcx_q, rcx_d, rcy_q, rcy_d;
	logic                      tok_q, tok_d, hitv_q, hitv_d;
	logic [NW-1:0]             cntt_q, cntt_d, n_q, n_d, i_q, i_d, j_q, j_d;
	logic [spgb_pkg::K_W-1:0]  k_q, k_d;
	logic [1:0]                stat_q, stat_d;
	logic [spgb_pkg::CIDX_W-1:0] qcell_q, qcell_d;

	logic accept;
	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;

	// ---------------- memories ----------------
	logic [2*CW-1:0]           obj_mem [spgb_pkg::NUM_OBJ];
	logic [spgb_pkg::NUM_OBJ-1:0] obj_valid_q;
	logic [2*CW-1:0]           obj_rd_q;
	logic                      objv_rd_q;
	logic                      obj_set, obj_clr;

	logic [NW-1:0]             cnt_mem [spgb_pkg::NUM_CELL];
	logic [spgb_pkg::NUM_CELL-1:0] cnt_valid_q;
	logic [NW-1:0]             cnt_rd_q, cnt_now, cnt_wd;
	logic                      cntv_rd_q, cnt_re, cnt_we;
	logic [spgb_pkg::CIDX_W-1:0] cnt_ra, cnt_wa;

	logic [IW-1:0]             mem_mem [spgb_pkg::NUM_SLOT];
	logic [IW-1:0]             mem_rd_q, mem_wd;
	logic                      mem_re, mem_we;
	logic [spgb_pkg::MIDX_W-1:0] mem_ra, mem_wa;

	logic [IW-1:0]             in_id;
	assign in_id = s_tdata[IW-1:0];

	always_ff @(posedge clk) begin
		if (obj_set) obj_mem[id_q] <= {ty_q, tx_q};
		if (accept) obj_rd_q <= obj_mem[in_id];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			obj_valid_q <= '0;
			objv_rd_q   <= 1'b0;
		end else begin
			if (obj_set) obj_valid_q[id_q] <= 1'b1;
			else if (obj_clr) obj_valid_q[id_q] <= 1'b0;
			if (accept) objv_rd_q <= obj_valid_q[in_id];
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (cnt_re) cnt_rd_q <= cnt_mem[cnt_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_valid_q <= '0;
			cntv_rd_q   <= 1'b0;
		end else begin
			if (cnt_we) cnt_valid_q[cnt_wa] <= 1'b1;
			if (cnt_re) cntv_rd_q <= cnt_valid_q[cnt_ra];
		end
	end

	assign cnt_now = cntv_rd_q ? cnt_rd_q : '0;

	always_ff @(posedge clk) begin
		if (mem_we) mem_mem[mem_wa] <= mem_wd;
		if (mem_re) mem_rd_q <= mem_mem[mem_ra];
	end

	// ---------------- position to cell ----------------
	logic [16:0] pxe, pye, pabx, paby, ab2x, ab2y, numx, numy, denx, deny, quox, quoy;
	logic        smallx, smally, divs, donex, doney;
	logic [CW-1:0] cellx, celly;
	logic        okx, oky;

	assign pxe  = {px_q[15], px_q};
	assign pye  = {py_q[15], py_q};
	assign pabx = px_q[15] ? 17'(-pxe) : pxe;
	assign paby = py_q[15] ? 17'(-pye) : pye;
	assign ab2x = {pabx[15:0], 1'b0};
	assign ab2y = {paby[15:0], 1'b0};
	assign smallx = ab2x <= {1'b0, cw_q};
	assign smally = ab2y <= {1'b0, ch_q};
	assign numx = 17'(18'(ab2x) + 18'(cw_q) - 18'd2);
	assign numy = 17'(18'(ab2y) + 18'(ch_q) - 18'd2);
	assign denx = {cw_q, 1'b0};
	assign deny = {ch_q, 1'b0};
	assign divs = (state_q == S_DIVS);

	spgb_div u_divx (.clk, .arst_n, .start(divs), .num(numx), .den(denx),
		.done(donex), .quot(quox));
	spgb_div u_divy (.clk, .arst_n, .start(divs), .num(numy), .den(deny),
		.done(doney), .quot(quoy));

	always_comb begin
		if (smallx) begin
			okx = 1'b1; cellx = '0;
		end else if (!px_q[15]) begin
			okx = quox <= 17'd7; cellx = quox[CW-1:0];
		end else begin
			okx = quox <= 17'd8; cellx = CW'(4'd0 - quox[CW-1:0]);
		end
		if (smally) begin
			oky = 1'b1; celly = '0;
		end else if (!py_q[15]) begin
			oky = quoy <= 17'd7; celly = quoy[CW-1:0];
		end else begin
			oky = quoy <= 17'd8; celly = CW'(4'd0 - quoy[CW-1:0]);
		end
	end

	// ---------------- query neighbour ----------------
	logic [4:0] nbx, nby;
	logic       nb_in;
	logic [1:0] dxk, dyk;
	assign dxk   = spgb_pkg::q_dx(k_q);
	assign dyk   = spgb_pkg::q_dy(k_q);
	assign nbx   = {qx_q[CW-1], qx_q} + {{3{dxk[1]}}, dxk};
	assign nby   = {qy_q[CW-1], qy_q} + {{3{dyk[1]}}, dyk};
	assign nb_in = (nbx[4] == nbx[3]) && (nby[4] == nby[3]);

	// ---------------- output register ----------------
	logic        out_free, out_emit, out_found, out_last;
	logic [1:0]  out_status;
	logic [IW-1:0] out_id;
	logic [CW-1:0] out_rcx, out_rcy;
	logic        m_valid_q;

	assign out_free = !m_valid_q || m_tready;

	// ---------------- sequencer ----------------
	logic [spgb_pkg::CIDX_W-1:0] tcell, ocell;
	logic [NW-1:0] j_next;
	assign tcell  = spgb_pkg::cell_index(tx_q, ty_q);
	assign ocell  = spgb_pkg::cell_index(ocx_q, ocy_q);
	assign j_next = (mem_rd_q != id_q) ? j_q + NW'(1) : j_q;

	always_comb begin
		state_d = state_q; kind_d = kind_q; id_d = id_q; px_d = px_q; py_d = py_q;
		qx_d = qx_q; qy_d = qy_q; tx_d = tx_q; ty_d = ty_q; tok_d = tok_q;
		ocx_d = ocx_q; ocy_d = ocy_q; cntt_d = cntt_q; k_d = k_q; n_d = n_q;
		i_d = i_q; j_d = j_q; stat_d = stat_q; rcx_d = rcx_q; rcy_d = rcy_q;
		hit_d = hit_q; hitv_d = hitv_q; qcell_d = qcell_q;
		obj_set = 1'b0; obj_clr = 1'b0;
		cnt_re = 1'b0; cnt_ra = tcell; cnt_we = 1'b0; cnt_wa = tcell; cnt_wd = '0;
		mem_re = 1'b0; mem_ra = {ocell, i_q[spgb_pkg::SLOT_W-1:0]};
		mem_we = 1'b0; mem_wa = {ocell, j_q[spgb_pkg::SLOT_W-1:0]}; mem_wd = mem_rd_q;
		out_emit = 1'b0; out_status = stat_q; out_id = id_q; out_found = 1'b0;
		out_rcx = rcx_q; out_rcy = rcy_q; out_last = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					kind_d = s_tuser;
					id_d   = in_id;
					px_d   = s_tdata[21:6];
					py_d   = s_tdata[37:22];
					qx_d   = s_tdata[41:38];
					qy_d   = s_tdata[45:42];
					tx_d   = s_tdata[41:38];
					ty_d   = s_tdata[45:42];
					tok_d  = 1'b1;
					rcx_d  = '0;
					rcy_d  = '0;
					k_d    = '0;
					hitv_d = 1'b0;
					if (s_tuser == spgb_pkg::KIND_PLACE_POS || s_tuser == spgb_pkg::KIND_MOVE)
						state_d = S_DIVS;
					else if (s_tuser == spgb_pkg::KIND_QUERY)
						state_d = S_QCELL;
					else if (s_tuser == spgb_pkg::KIND_PLACE_CELL ||
							s_tuser == spgb_pkg::KIND_REMOVE)
						state_d = S_CHK;
					else begin
						stat_d  = spgb_pkg::ST_BAD;
						state_d = S_EMIT;
					end
				end
			end
			S_DIVS: state_d = S_DIV;
			S_DIV: begin
				if (donex && doney) begin
					tx_d    = cellx;
					ty_d    = celly;
					tok_d   = okx && oky;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				ocx_d = obj_rd_q[CW-1:0];
				ocy_d = obj_rd_q[2*CW-1:CW];
				state_d = S_EMIT;
				if (kind_q == spgb_pkg::KIND_REMOVE) begin
					if (!objv_rd_q) stat_d = spgb_pkg::ST_BAD;
					else begin
						cnt_re  = 1'b1;
						cnt_ra  = spgb_pkg::cell_index(obj_rd_q[CW-1:0], obj_rd_q[2*CW-1:CW]);
						state_d = S_DRCNT;
					end
				end else if (kind_q == spgb_pkg::KIND_MOVE) begin
					if (!objv_rd_q) stat_d = spgb_pkg::ST_BAD;
					else if (!tok_q) stat_d = spgb_pkg::ST_OUTSIDE;
					else if (tx_q == obj_rd_q[CW-1:0] && ty_q == obj_rd_q[2*CW-1:CW]) begin
						stat_d = spgb_pkg::ST_OK;
						rcx_d  = tx_q;
						rcy_d  = ty_q;
					end else begin
						cnt_re  = 1'b1;
						state_d = S_TCNT;
					end
				end else begin
					if (objv_rd_q) stat_d = spgb_pkg::ST_BAD;
					else if (!tok_q) stat_d = spgb_pkg::ST_OUTSIDE;
					else begin
						cnt_re  = 1'b1;
						state_d = S_TCNT;
					end
				end
			end
			S_TCNT: begin
				cntt_d = cnt_now;
				if (cnt_now >= NW'(spgb_pkg::CELL_CAP)) begin
					stat_d  = spgb_pkg::ST_FULL;
					state_d = S_EMIT;
				end else if (kind_q == spgb_pkg::KIND_MOVE) begin
					cnt_re  = 1'b1;
					cnt_ra  = ocell;
					state_d = S_DRCNT;
				end else
					state_d = S_APP;
			end
			S_DRCNT: begin
				n_d     = cnt_now;
				i_d     = '0;
				j_d     = '0;
				mem_re  = 1'b1;
				mem_ra  = {ocell, {spgb_pkg::SLOT_W{1'b0}}};
				state_d = S_DRRD;
			end
			S_DRRD: begin
				// compact the old cell list, keeping order
				if (mem_rd_q != id_q) mem_we = 1'b1;
				j_d = j_next;
				i_d = i_q + NW'(1);
				if (i_q + NW'(1) < n_q) begin
					mem_re = 1'b1;
					mem_ra = {ocell, 2'(i_q + NW'(1))};
				end else begin
					cnt_we  = 1'b1;
					cnt_wa  = ocell;
					cnt_wd  = j_next;
					obj_clr = 1'b1;
					if (kind_q == spgb_pkg::KIND_MOVE) state_d = S_APP;
					else begin
						stat_d  = spgb_pkg::ST_OK;
						state_d = S_EMIT;
					end
				end
			end
			S_APP: begin
				mem_we  = 1'b1;
				mem_wa  = {tcell, cntt_q[spgb_pkg::SLOT_W-1:0]};
				mem_wd  = id_q;
				cnt_we  = 1'b1;
				cnt_wd  = cntt_q + NW'(1);
				obj_set = 1'b1;
				stat_d  = spgb_pkg::ST_OK;
				rcx_d   = tx_q;
				rcy_d   = ty_q;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_free) begin
					out_emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_QCELL: begin
				if (nb_in) begin
					qcell_d = spgb_pkg::cell_index(nbx[CW-1:0], nby[CW-1:0]);
					cnt_re  = 1'b1;
					cnt_ra  = spgb_pkg::cell_index(nbx[CW-1:0], nby[CW-1:0]);
					state_d = S_QCNT;
				end else if (k_q == spgb_pkg::K_LAST)
					state_d = S_QEND;
				else
					k_d = k_q + spgb_pkg::K_W'(1);
			end
			S_QCNT: begin
				n_d = cnt_now;
				i_d = '0;
				if (cnt_now == '0) begin
					if (k_q == spgb_pkg::K_LAST) state_d = S_QEND;
					else begin
						k_d     = k_q + spgb_pkg::K_W'(1);
						state_d = S_QCELL;
					end
				end else begin
					mem_re  = 1'b1;
					mem_ra  = {qcell_q, {spgb_pkg::SLOT_W{1'b0}}};
					state_d = S_QMEM;
				end
			end
			S_QMEM: begin
				// hold one hit back so the final one can carry last
				if (!hitv_q || out_free) begin
					if (hitv_q) begin
						out_emit   = 1'b1;
						out_status = spgb_pkg::ST_OK;
						out_id     = hit_q;
						out_found  = 1'b1;
						out_rcx    = '0;
						out_rcy    = '0;
						out_last   = 1'b0;
					end
					hit_d  = mem_rd_q;
					hitv_d = 1'b1;
					i_d    = i_q + NW'(1);
					if (i_q + NW'(1) < n_q) begin
						mem_re = 1'b1;
						mem_ra = {qcell_q, 2'(i_q + NW'(1))};
					end else if (k_q == spgb_pkg::K_LAST)
						state_d = S_QEND;
					else begin
						k_d     = k_q + spgb_pkg::K_W'(1);
						state_d = S_QCELL;
					end
				end
			end
			S_QEND: begin
				if (out_free) begin
					out_emit   = 1'b1;
					out_status = spgb_pkg::ST_OK;
					out_rcx    = '0;
					out_rcy    = '0;
					out_id     = hitv_q ? hit_q : id_q;
					out_found  = hitv_q;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			hitv_q  <= 1'b0;
			k_q     <= '0;
			i_q     <= '0;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			hitv_q  <= hitv_d;
			k_q     <= k_d;
			i_q     <= i_d;
			n_q     <= n_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d; id_q <= id_d; px_q <= px_d; py_q <= py_d;
		qx_q <= qx_d; qy_q <= qy_d; tx_q <= tx_d; ty_q <= ty_d; tok_q <= tok_d;
		ocx_q <= ocx_d; ocy_q <= ocy_d; cntt_q <= cntt_d; j_q <= j_d;
		stat_q <= stat_d; rcx_q <= rcx_d; rcy_q <= rcy_d; hit_q <= hit_d;
		qcell_q <= qcell_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_valid_q <= 1'b0;
		else if (out_emit) m_valid_q <= 1'b1;
		else if (m_tready) m_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_emit) begin
			m_tdata <= {out_rcy, out_rcx, out_id, out_status};
			m_tuser <= out_found;
			m_tlast <= out_last;
		end
	end

	assign m_tvalid = m_valid_q;

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("item taken while busy");
	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[1:0] == spgb_pkg::ST_OK)
		else $error("query hit with error status");
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_we |-> cnt_wd <= NW'(spgb_pkg::CELL_CAP)) else $error("cell count overflow");
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_emit |-> out_free) else $error("result overwrites pending item");

endmodule
